// ===== design/palette_rle_frame_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// palette_rle_frame_decoder_macros.svh
// assertion helpers for the decoder rtl
// ----------------------------------------------------------------------------
`ifndef PALETTE_RLE_FRAME_DECODER_MACROS_SVH
`define PALETTE_RLE_FRAME_DECODER_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define PLR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/plr_pkg.sv =====
// ----------------------------------------------------------------------------
// plr_pkg
// shared constants and types of the palette run-length frame decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plr_pkg;

  localparam int CELLS   = 4096;
  localparam int POS_W   = 13;
  localparam int CNT_W   = 13;
  localparam int LEN_W   = 13;
  localparam int PCNT_W  = 9;
  localparam int PAL_AW  = 8;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // configuration register indexes
  localparam logic [1:0] REG_UNIFORM_TAG = 2'd0;
  localparam logic [1:0] REG_RAW_TAG     = 2'd1;
  localparam logic [1:0] REG_RLE_TAG     = 2'd2;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_UNIFORM = 2'd1,
    KIND_RAW     = 2'd2,
    KIND_RLE     = 2'd3
  } kind_t;

  // one result as it leaves the parser
  typedef struct packed {
    logic             has_result;
    logic             run_valid;
    logic             use_palette;
    logic [7:0]       id;
    logic [LEN_W-1:0] len;
    logic             done;
    logic             ok;
  } res_t;

endpackage

// ===== design/plr_palette_ram.sv =====
// ----------------------------------------------------------------------------
// plr_palette_ram
// 256 x 8 palette store, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plr_palette_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [plr_pkg::PAL_AW-1:0] waddr,
  input  logic [7:0]                wdata,
  input  logic                      re,
  input  logic [plr_pkg::PAL_AW-1:0] raddr,
  output logic [7:0]                rdata
);

  logic [7:0] mem [2**plr_pkg::PAL_AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/plr_frame_parser.sv =====
// ----------------------------------------------------------------------------
// plr_frame_parser
// per-byte frame parsing, control state and palette access
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plr_frame_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic [7:0]                 frame_byte,
  input  logic                       frame_last,
  input  logic [7:0]                 uniform_tag,
  input  logic [7:0]                 raw_tag,
  input  logic [7:0]                 rle_tag,
  output plr_pkg::res_t              result,
  output logic                       pal_we,
  output logic [plr_pkg::PAL_AW-1:0] pal_waddr,
  output logic                       pal_re,
  output logic [plr_pkg::PAL_AW-1:0] pal_raddr
);

  logic [plr_pkg::POS_W-1:0]  byte_position, byte_position_next;
  plr_pkg::kind_t             frame_kind, frame_kind_next;
  logic [plr_pkg::PCNT_W-1:0] palette_count, palette_count_next;
  logic [plr_pkg::PCNT_W-1:0] pending_length, pending_length_next;
  logic [plr_pkg::CNT_W-1:0]  cells_filled, cells_filled_next;
  logic                       frame_error, frame_error_next;

  // byte decode
  plr_pkg::kind_t             tag_kind, kind_upd;
  logic                       p_zero, p_one, active;
  logic                       u_run, u_bad, raw_cell, raw_bad;
  logic                       rle, in_palette, r_count, r_pal, r_len, r_pair;
  logic                       pair_bad, r_run;
  logic [plr_pkg::PCNT_W:0]   pal_end;
  logic [plr_pkg::CNT_W:0]    cells_sum;
  logic [plr_pkg::PCNT_W-1:0] byte_plus1;
  logic                       err_upd;
  logic [plr_pkg::PCNT_W-1:0] pc_upd, pend_upd;
  logic [plr_pkg::CNT_W-1:0]  cells_upd;
  logic                       frame_good;

  always_comb begin
    if (frame_byte == uniform_tag) begin
      tag_kind = plr_pkg::KIND_UNIFORM;
    end else if (frame_byte == raw_tag) begin
      tag_kind = plr_pkg::KIND_RAW;
    end else if (frame_byte == rle_tag) begin
      tag_kind = plr_pkg::KIND_RLE;
    end else begin
      tag_kind = plr_pkg::KIND_NONE;
    end

    p_zero     = (byte_position == '0);
    p_one      = (byte_position == plr_pkg::POS_W'(1));
    active     = !p_zero && !frame_error;
    byte_plus1 = {1'b0, frame_byte} + plr_pkg::PCNT_W'(1);

    u_run    = active && (frame_kind == plr_pkg::KIND_UNIFORM) && p_one;
    u_bad    = active && (frame_kind == plr_pkg::KIND_UNIFORM) && !p_one;
    raw_cell = active && (frame_kind == plr_pkg::KIND_RAW) && !p_one &&
               (cells_filled < plr_pkg::CNT_W'(plr_pkg::CELLS));
    raw_bad  = active && (frame_kind == plr_pkg::KIND_RAW) && !p_one &&
               !(cells_filled < plr_pkg::CNT_W'(plr_pkg::CELLS));

    rle        = active && (frame_kind == plr_pkg::KIND_RLE);
    pal_end    = {1'b0, palette_count} + (plr_pkg::PCNT_W + 1)'(2);
    in_palette = ({1'b0, byte_position} < {{(plr_pkg::POS_W - plr_pkg::PCNT_W){1'b0}}, pal_end});
    r_count    = rle && p_one;
    r_pal      = rle && !p_one && in_palette;
    r_len      = rle && !p_one && !in_palette && (pending_length == '0);
    r_pair     = rle && !p_one && !in_palette && (pending_length != '0);

    cells_sum = {1'b0, cells_filled} + {{(plr_pkg::CNT_W + 1 - plr_pkg::PCNT_W){1'b0}},
                                        pending_length};
    pair_bad  = ({1'b0, frame_byte} >= palette_count) ||
                (cells_sum > (plr_pkg::CNT_W + 1)'(plr_pkg::CELLS));
    r_run     = r_pair && !pair_bad;
  end

  // state after this byte, before the end-of-frame clear
  always_comb begin
    kind_upd  = p_zero ? tag_kind : frame_kind;
    err_upd   = frame_error || (p_zero && (tag_kind == plr_pkg::KIND_NONE)) ||
                (p_zero && frame_last) || u_bad || raw_bad || (r_pair && pair_bad);
    pc_upd    = r_count ? byte_plus1 : palette_count;
    pend_upd  = r_len ? byte_plus1 : (r_pair ? '0 : pending_length);
    cells_upd = cells_filled;
    if (raw_cell) begin
      cells_upd = cells_filled + plr_pkg::CNT_W'(1);
    end else if (r_run) begin
      cells_upd = cells_sum[plr_pkg::CNT_W-1:0];
    end

    if (frame_last) begin
      byte_position_next  = '0;
      frame_kind_next     = plr_pkg::KIND_NONE;
      palette_count_next  = '0;
      pending_length_next = '0;
      cells_filled_next   = '0;
      frame_error_next    = 1'b0;
    end else begin
      byte_position_next  = (byte_position == plr_pkg::POS_MAX) ? byte_position :
                            byte_position + plr_pkg::POS_W'(1);
      frame_kind_next     = kind_upd;
      palette_count_next  = pc_upd;
      pending_length_next = pend_upd;
      cells_filled_next   = cells_upd;
      frame_error_next    = err_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      frame_kind     <= plr_pkg::KIND_NONE;
      palette_count  <= '0;
      pending_length <= '0;
      cells_filled   <= '0;
      frame_error    <= 1'b0;
    end else if (take) begin
      byte_position  <= byte_position_next;
      frame_kind     <= frame_kind_next;
      palette_count  <= palette_count_next;
      pending_length <= pending_length_next;
      cells_filled   <= cells_filled_next;
      frame_error    <= frame_error_next;
    end
  end

  // result and palette access
  always_comb begin
    frame_good = 1'b0;
    unique case (kind_upd)
      plr_pkg::KIND_UNIFORM: frame_good = 1'b1;
      plr_pkg::KIND_RAW:     frame_good = (cells_upd == plr_pkg::CNT_W'(plr_pkg::CELLS));
      plr_pkg::KIND_RLE: begin
        frame_good = ({1'b0, byte_position} + (plr_pkg::POS_W + 1)'(1) >=
                      (plr_pkg::POS_W + 1)'(pc_upd) + (plr_pkg::POS_W + 1)'(2)) &&
                     (pend_upd == '0) &&
                     (cells_upd == plr_pkg::CNT_W'(plr_pkg::CELLS));
      end
      default:               frame_good = 1'b0;
    endcase

    result.run_valid   = u_run || raw_cell || r_run;
    result.has_result  = result.run_valid || frame_last;
    result.use_palette = r_run;
    result.id          = (u_run || raw_cell) ? frame_byte : 8'd0;
    if (u_run) begin
      result.len = plr_pkg::LEN_W'(plr_pkg::CELLS);
    end else if (raw_cell) begin
      result.len = plr_pkg::LEN_W'(1);
    end else if (r_run) begin
      result.len = plr_pkg::LEN_W'(pending_length);
    end else begin
      result.len = '0;
    end
    result.done = frame_last;
    result.ok   = frame_last && !err_upd && frame_good;

    pal_we    = take && r_pal;
    pal_waddr = byte_position[plr_pkg::PAL_AW-1:0] - plr_pkg::PAL_AW'(2);
    pal_re    = take && r_run;
    pal_raddr = frame_byte;
  end

endmodule

// ===== design/palette_rle_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// palette_rle_frame_decoder
// decodes uniform, raw and palette rle frames into runs of cell ids
// ----------------------------------------------------------------------------
//
//   channel   signals                                       direction
//   -------   -------------------------------------------   ---------
//   in        in_valid/in_ready, frame_byte, frame_last     request in
//   out       out_valid/out_ready, run_valid, cell_id,      request out
//             run_length, frame_done, frame_ok
//   cfg       apb: psel, penable, pwrite, paddr, pwdata,     register port
//             prdata, pready
//
// one byte per cycle while the output is not stalled; the accepting edge parses
// a request into the middle stage and issues its palette read, and the output
// register loads from the middle stage whenever that stage can move on
// the palette read of a run's index byte completes as the middle stage loads
// synchronous reset clears control state; the palette ram is not cleared
// and needs no clearing pass
// with the output stalled the middle stage still takes one more request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "palette_rle_frame_decoder_macros.svh"

module palette_rle_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  // byte stream in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  frame_byte,
  input  logic        frame_last,
  // runs out
  output logic        out_valid,
  input  logic        out_ready,
  output logic        run_valid,
  output logic [7:0]  cell_id,
  output logic [12:0] run_length,
  output logic        frame_done,
  output logic        frame_ok,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // tag registers
  logic [7:0] uniform_tag, raw_tag, rle_tag;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      uniform_tag <= 8'd0;
      raw_tag     <= 8'd1;
      rle_tag     <= 8'd2;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        plr_pkg::REG_UNIFORM_TAG: uniform_tag <= pwdata[7:0];
        plr_pkg::REG_RAW_TAG:     raw_tag     <= pwdata[7:0];
        plr_pkg::REG_RLE_TAG:     rle_tag     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      plr_pkg::REG_UNIFORM_TAG: prdata = {24'd0, uniform_tag};
      plr_pkg::REG_RAW_TAG:     prdata = {24'd0, raw_tag};
      plr_pkg::REG_RLE_TAG:     prdata = {24'd0, rle_tag};
      default:                  prdata = 32'd0;
    endcase
  end

  // pipeline control: parse stage -> middle stage (s2) -> output register
  logic          take, s2_move;
  logic          s2_valid;
  plr_pkg::res_t s2_res, parse_res;

  logic                       pal_we, pal_re;
  logic [plr_pkg::PAL_AW-1:0] pal_waddr, pal_raddr;
  logic [7:0]                 pal_rdata;

  assign s2_move  = !out_valid || out_ready;
  assign in_ready = !s2_valid || s2_move;
  assign take     = in_valid && in_ready;

  plr_frame_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .frame_byte  (frame_byte),
    .frame_last  (frame_last),
    .uniform_tag (uniform_tag),
    .raw_tag     (raw_tag),
    .rle_tag     (rle_tag),
    .result      (parse_res),
    .pal_we      (pal_we),
    .pal_waddr   (pal_waddr),
    .pal_re      (pal_re),
    .pal_raddr   (pal_raddr)
  );

  // palette writes of a frame always finish before its first index read,
  // with at least the length byte in between, so no forwarding is needed
  plr_palette_ram u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (frame_byte),
    .re    (pal_re),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  // middle stage: waits for the palette read; bytes with no result skip it
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (take) begin
      s2_valid <= parse_res.has_result;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s2_res <= parse_res;
    end
  end

  // output register; palette read data is only replaced by the next take,
  // which cannot happen while s2 holds a stalled request
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_move) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      run_valid  <= s2_res.run_valid;
      cell_id    <= s2_res.use_palette ? pal_rdata : s2_res.id;
      run_length <= s2_res.len;
      frame_done <= s2_res.done;
      frame_ok   <= s2_res.ok;
    end
  end

  // checks
  `PLR_ASSERT_IMP(a_ok_needs_done, clk, rst, out_valid && frame_ok, frame_done,
    "frame_ok without frame_done")
  `PLR_ASSERT_IMP(a_run_nonzero, clk, rst, out_valid && run_valid, run_length != 13'd0,
    "run of zero length")
  `PLR_ASSERT_NXT(a_s2_holds, clk, rst, s2_valid && !s2_move,
    s2_valid && $stable(s2_res) && (!s2_res.use_palette || $stable(pal_rdata)),
    "middle stage lost its request while stalled")

endmodule

// ===== test/tb_palette_rle_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_palette_rle_frame_decoder
// self-checking bench for the palette run-length frame decoder
//
// a queue of frame bytes feeds a valid/ready driver; a monitor compares every
// output request field by field against a cycle-free decoder model that runs
// on each accepted byte. the bench reads back the tag registers, sends
// directed short frames, then random frame mixes under several tag settings.
// both sides idle at random, and the output side sometimes holds off long
// enough to back up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_palette_rle_frame_decoder;

  localparam int STUCK_LIMIT = 4000;  // cycles with no progress before giving up
  localparam int SETTLE_CYCLES = 8;   // covers the two-stage pipe plus margin
  localparam int PHASE_BYTES = 80;    // random bytes per tag setting

  typedef struct packed {
    logic [7:0] b;
    logic       is_last;
  } stream_byte_t;

  typedef struct packed {
    logic                      run_valid;
    logic [7:0]                id;
    logic [plr_pkg::LEN_W-1:0] len;
    logic                      done;
    logic                      ok;
  } run_result_t;

  // dut signals
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  frame_byte = 8'd0;
  logic        frame_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        run_valid;
  logic [7:0]  cell_id;
  logic [12:0] run_length;
  logic        frame_done;
  logic        frame_ok;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  palette_rle_frame_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .frame_byte(frame_byte),
    .frame_last(frame_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .run_valid (run_valid),
    .cell_id   (cell_id),
    .run_length(run_length),
    .frame_done(frame_done),
    .frame_ok  (frame_ok),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  // stimulus and expectation stores
  stream_byte_t byte_queue[$];
  logic [7:0]   frame_buf[$];
  run_result_t  expected_runs[$];

  // bookkeeping
  int unsigned bytes_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned frames_sent = 0;
  int unsigned runs_checked = 0;
  int unsigned frames_good = 0;
  int unsigned frames_bad = 0;
  int unsigned tag_settings = 0;
  int unsigned long_holds = 0;
  int unsigned error_count = 0;
  int unsigned stuck_cycles = 0;

  // ---------------------------------------------------------------------------
  // decoder model: tag copies plus per-frame parse state
  // ---------------------------------------------------------------------------
  logic [7:0]                 tag_uniform = 8'd0;
  logic [7:0]                 tag_raw = 8'd1;
  logic [7:0]                 tag_rle = 8'd2;
  logic [plr_pkg::POS_W-1:0]  dec_pos = '0;
  plr_pkg::kind_t             dec_kind = plr_pkg::KIND_NONE;
  logic [plr_pkg::PCNT_W-1:0] dec_pal_cnt = '0;
  logic [7:0]                 dec_palette[256];
  logic [8:0]                 dec_pending = '0;
  logic [plr_pkg::CNT_W-1:0]  dec_filled = '0;
  logic                       dec_bad = 1'b0;

  // advance the model by one accepted byte, queue the request it produces
  function automatic void decode_byte(input logic [7:0] b, input logic is_last);
    logic [plr_pkg::POS_W-1:0] p;
    logic                      fire;
    logic [7:0]                id;
    logic [plr_pkg::LEN_W-1:0] len;
    logic                      ok;
    run_result_t               res;
    p = dec_pos;
    fire = 1'b0;
    id = '0;
    len = '0;
    ok = 1'b0;

    if (p == 0) begin
      // tag byte, uniform takes priority over raw, raw over rle
      if (b == tag_uniform) dec_kind = plr_pkg::KIND_UNIFORM;
      else if (b == tag_raw) dec_kind = plr_pkg::KIND_RAW;
      else if (b == tag_rle) dec_kind = plr_pkg::KIND_RLE;
      else dec_bad = 1'b1;
      if (is_last) dec_bad = 1'b1;
    end else if (!dec_bad) begin
      case (dec_kind)
        plr_pkg::KIND_UNIFORM: begin
          if (p == 1) begin
            fire = 1'b1;
            id = b;
            len = plr_pkg::LEN_W'(plr_pkg::CELLS);
          end else begin
            dec_bad = 1'b1;
          end
        end
        plr_pkg::KIND_RAW: begin
          // byte 1 is reserved
          if (p >= 2) begin
            if (dec_filled < plr_pkg::CNT_W'(plr_pkg::CELLS)) begin
              fire = 1'b1;
              id = b;
              len = plr_pkg::LEN_W'(1);
              dec_filled++;
            end else begin
              dec_bad = 1'b1;
            end
          end
        end
        plr_pkg::KIND_RLE: begin
          if (p == 1) begin
            dec_pal_cnt = plr_pkg::PCNT_W'(b) + plr_pkg::PCNT_W'(1);
          end else if (int'(p) < 2 + int'(dec_pal_cnt)) begin
            dec_palette[8'(p - 2)] = b;
          end else if (dec_pending == 0) begin
            dec_pending = 9'(b) + 9'd1;
          end else begin
            if (b >= dec_pal_cnt ||
                int'(dec_filled) + int'(dec_pending) > plr_pkg::CELLS) begin
              dec_bad = 1'b1;
            end else begin
              fire = 1'b1;
              id = dec_palette[b];
              len = plr_pkg::LEN_W'(dec_pending);
              dec_filled += plr_pkg::CNT_W'(dec_pending);
            end
            dec_pending = '0;
          end
        end
        default: ;
      endcase
    end

    if (dec_bad) fire = 1'b0;
    if (dec_pos != plr_pkg::POS_MAX) dec_pos++;

    if (is_last) begin
      if (!dec_bad) begin
        case (dec_kind)
          plr_pkg::KIND_UNIFORM: ok = 1'b1;
          plr_pkg::KIND_RAW:     ok = (dec_filled == plr_pkg::CNT_W'(plr_pkg::CELLS));
          plr_pkg::KIND_RLE:     ok = (int'(p) + 1 >= 2 + int'(dec_pal_cnt)) &&
                                      (dec_pending == 0) &&
                                      (dec_filled == plr_pkg::CNT_W'(plr_pkg::CELLS));
          default: ;
        endcase
      end
      dec_pos = '0;
      dec_kind = plr_pkg::KIND_NONE;
      dec_pal_cnt = '0;
      dec_pending = '0;
      dec_filled = '0;
      dec_bad = 1'b0;
    end

    if (fire || is_last) begin
      res.run_valid = fire;
      res.id = id;
      res.len = len;
      res.done = is_last;
      res.ok = ok;
      expected_runs.push_back(res);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------
  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(input string what, input int unsigned want_v,
                                      input int unsigned got_v);
    if (want_v != got_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
    end
  endfunction

  // move the frame under construction into the byte queue, flag the last byte
  function automatic void flush_frame();
    stream_byte_t sb;
    foreach (frame_buf[k]) begin
      sb.b = frame_buf[k];
      sb.is_last = (k == frame_buf.size() - 1);
      byte_queue.push_back(sb);
    end
    bytes_queued += frame_buf.size();
    frames_sent++;
    frame_buf.delete();
  endfunction

  // rle frame with a random palette and random runs that fill the chunk,
  // optionally broken in one of several ways
  function automatic void build_rle(input logic corrupt);
    int n;
    int left;
    int run;
    int pairs;
    int k;
    int mode;
    int cut;
    int r;
    r = $urandom_range(0, 9);
    n = (r < 7) ? $urandom_range(1, 8) : (r < 9) ? $urandom_range(9, 255) : 256;
    frame_buf.push_back(tag_rle);
    frame_buf.push_back(8'(n - 1));
    repeat (n) frame_buf.push_back(8'($urandom));
    left = plr_pkg::CELLS;
    while (left > 0) begin
      run = $urandom_range(1, (left < 256) ? left : 256);
      frame_buf.push_back(8'(run - 1));
      frame_buf.push_back(8'($urandom_range(0, n - 1)));
      left -= run;
    end
    if (corrupt) begin
      mode = $urandom_range(0, 4);
      if (mode == 0 && n < 256) begin
        // index past the palette on one pair
        pairs = (frame_buf.size() - 2 - n) / 2;
        k = $urandom_range(0, pairs - 1);
        frame_buf[2 + n + 2 * k + 1] = 8'($urandom_range(n, 255));
      end else if (mode <= 1) begin
        // one extra pair overflows the chunk
        frame_buf.push_back(8'($urandom));
        frame_buf.push_back(8'($urandom_range(0, n - 1)));
      end else if (mode == 2) begin
        // cut short: lone length byte or too few cells
        repeat ($urandom_range(1, 6)) void'(frame_buf.pop_back());
      end else if (mode == 3) begin
        // dangling length byte after a full chunk
        frame_buf.push_back(8'($urandom));
      end else begin
        // ends inside the palette
        cut = $urandom_range(0, n - 1);
        while (frame_buf.size() > 2 + cut) void'(frame_buf.pop_back());
      end
    end
    flush_frame();
  endfunction

  function automatic void gen_random_frames(input int unsigned budget);
    int unsigned start;
    int unsigned r;
    logic [7:0]  t;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        build_rle($urandom_range(0, 3) == 0);
      end else if (r < 75) begin
        // uniform: mostly well formed, some one byte short or too long
        frame_buf.push_back(tag_uniform);
        r = $urandom_range(0, 19);
        if (r < 15) frame_buf.push_back(8'($urandom));
        else if (r >= 17) repeat ($urandom_range(2, 5)) frame_buf.push_back(8'($urandom));
        flush_frame();
      end else if (r < 87) begin
        // raw frames here are always short
        frame_buf.push_back(tag_raw);
        repeat ($urandom_range(0, 30)) frame_buf.push_back(8'($urandom));
        flush_frame();
      end else begin
        // unknown tag followed by noise
        do t = 8'($urandom); while (t == tag_uniform || t == tag_raw || t == tag_rle);
        frame_buf.push_back(t);
        repeat ($urandom_range(0, 8)) frame_buf.push_back(8'($urandom));
        flush_frame();
      end
    end
  endfunction

  // one apb transfer: setup then access; a read is checked against the tag copy
  task automatic apb_access(input logic write, input logic [1:0] idx, input logic [7:0] val);
    logic [7:0] want;
    want = '0;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (write) begin
      case (idx)
        plr_pkg::REG_UNIFORM_TAG: tag_uniform = val;
        plr_pkg::REG_RAW_TAG:     tag_raw = val;
        plr_pkg::REG_RLE_TAG:     tag_rle = val;
        default: ;
      endcase
    end else begin
      case (idx)
        plr_pkg::REG_UNIFORM_TAG: want = tag_uniform;
        plr_pkg::REG_RAW_TAG:     want = tag_raw;
        plr_pkg::REG_RLE_TAG:     want = tag_rle;
        default: ;
      endcase
      if (prdata[7:0] !== want) begin
        error_count++;
        $display("%0t: register %0d readback, expected %0d, got %0d",
                 $time, idx, want, prdata[7:0]);
      end
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic read_tags();
    apb_access(1'b0, plr_pkg::REG_UNIFORM_TAG, 8'd0);
    apb_access(1'b0, plr_pkg::REG_RAW_TAG, 8'd0);
    apb_access(1'b0, plr_pkg::REG_RLE_TAG, 8'd0);
  endtask

  task automatic set_tags(input logic [7:0] u, input logic [7:0] w, input logic [7:0] l);
    apb_access(1'b1, plr_pkg::REG_UNIFORM_TAG, u);
    apb_access(1'b1, plr_pkg::REG_RAW_TAG, w);
    apb_access(1'b1, plr_pkg::REG_RLE_TAG, l);
    read_tags();
    tag_settings++;
  endtask

  // wait until every byte is taken and every request has come out, then let
  // the pipe settle so bytes without a result have cleared too
  task automatic drain_pipeline();
    while (!(items_accepted == bytes_queued && expected_runs.size() == 0)) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // input driver: change on falling edge, take on rising edge
  // ---------------------------------------------------------------------------
  stream_byte_t drive_item;
  logic         in_taken = 1'b0;
  logic         in_burst = 1'b0;
  int unsigned  in_gap = 0;

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      decode_byte(frame_byte, frame_last);
      in_taken = 1'b1;
      items_accepted++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      // burst mode gives stretches with no idle cycles at all
      if ($urandom_range(0, 199) == 0) in_burst = !in_burst;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        drive_item = byte_queue.pop_front();
        in_valid <= 1'b1;
        frame_byte <= drive_item.b;
        frame_last <= drive_item.is_last;
        in_gap = in_burst ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output side: ready with random stalls and occasional long holds
  // ---------------------------------------------------------------------------
  logic        out_burst = 1'b0;
  int unsigned out_stall = 0;
  int unsigned next_hold_at = 20;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      // long hold-off while plenty of bytes wait, so the pipe fills and
      // in_ready drops
      if (runs_checked >= next_hold_at && byte_queue.size() >= 40) begin
        out_stall = $urandom_range(300, 400);
        next_hold_at += 3000;
        long_holds++;
      end
      if ($urandom_range(0, 199) == 0) out_burst = !out_burst;
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!out_burst && $urandom_range(0, 2) == 0) out_stall = pick_gap();
      end
    end
  end

  // monitor: compare each accepted output request with the oldest expectation
  run_result_t got_run;
  run_result_t want_run;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_run.run_valid = run_valid;
      got_run.id = cell_id;
      got_run.len = run_length;
      got_run.done = frame_done;
      got_run.ok = frame_ok;
      if (expected_runs.size() == 0) begin
        error_count++;
        $display("%0t: unexpected output, expected none, got valid=%0b id=%0d",
                 $time, run_valid, cell_id);
        $display("%0t:   len=%0d done=%0b ok=%0b", $time, run_length, frame_done, frame_ok);
      end else begin
        want_run = expected_runs.pop_front();
        check_field("run_valid", want_run.run_valid, got_run.run_valid);
        check_field("cell_id", want_run.id, got_run.id);
        check_field("run_length", want_run.len, got_run.len);
        check_field("frame_done", want_run.done, got_run.done);
        check_field("frame_ok", want_run.ok, got_run.ok);
      end
      runs_checked++;
      if (frame_done) begin
        if (frame_ok) frames_good++;
        else frames_bad++;
      end
    end
  end

  // watchdog: cycles with work outstanding but no request moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (items_accepted == bytes_queued && expected_runs.size() == 0)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results still expected",
               $time, stuck_cycles, expected_runs.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  logic [7:0] tag_plan[6][3] = '{
    '{8'd0,   8'd1,   8'd2},    // reset values written back
    '{8'd255, 8'd254, 8'd253},  // top of range
    '{8'd9,   8'd9,   8'd40},   // uniform shadows raw
    '{8'd17,  8'd200, 8'd200},  // raw shadows rle
    '{8'd128, 8'd128, 8'd128},  // all equal, everything decodes as uniform
    '{8'd0,   8'd255, 8'd77}
  };

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // tags must come out of reset at their defaults
    read_tags();

    // directed short frames with the reset tags
    frame_buf = '{tag_uniform, 8'h00};              // uniform, lowest id
    flush_frame();
    frame_buf = '{tag_uniform, 8'hFF};              // uniform, highest id
    flush_frame();
    frame_buf = '{tag_rle};                         // tag only, too short
    flush_frame();
    frame_buf = '{tag_uniform, 8'h5A, 8'hA5};       // uniform with a trailing byte
    flush_frame();
    frame_buf = '{8'h80, 8'h01};                    // unknown tag
    flush_frame();
    frame_buf = '{tag_raw, 8'h00, 8'h3C, 8'hC3, 8'hFF};  // raw, far too short
    flush_frame();
    frame_buf = '{tag_rle, 8'h01, 8'h11, 8'h22, 8'h00, 8'h02};  // index past palette
    flush_frame();
    frame_buf = '{tag_rle, 8'h03, 8'h11};           // ends inside the palette
    flush_frame();
    frame_buf = '{tag_rle, 8'h00, 8'h7E, 8'hFF};    // ends on a lone length byte
    flush_frame();
    drain_pipeline();

    // random frame mixes under a series of tag settings
    for (int i = 0; i < 8; i++) begin
      if (i < 6) set_tags(tag_plan[i][0], tag_plan[i][1], tag_plan[i][2]);
      else set_tags(8'($urandom), 8'($urandom), 8'($urandom));
      gen_random_frames(PHASE_BYTES);
      drain_pipeline();
    end

    if (expected_runs.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected results never arrived", $time, expected_runs.size());
    end

    $display("checked %0d output requests from %0d bytes in %0d frames",
             runs_checked, items_accepted, frames_sent);
    $display("%0d good, %0d rejected, tag settings used: %0d, long output hold-offs: %0d",
             frames_good, frames_bad, tag_settings, long_holds);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
